[hw/rtl/cdd_pkg.sv]
// ----------------------------------------------------------------------------
// cdd_pkg - shared definitions for the coordinate dither descent block
// Widths, register indexes, reset values and the structs passed between
// the sequencer, the serial divider and the result queue.
// ----------------------------------------------------------------------------
package cdd_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PH_W       = $clog2(2 * CHANNELS + 1);

  localparam int SAMPLE_W   = 12;
  localparam int GAIN_W     = 12;
  localparam int DITHER_W   = 10;
  localparam int LEVEL_W    = 12;
  localparam int DVD_W      = 24;
  localparam int CNT_W      = $clog2(DVD_W + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Phase codes and limits
  localparam logic [PH_W-1:0] PHASE_BASE = '0;
  localparam logic [PH_W-1:0] PHASE_MAX  = PH_W'(2 * CHANNELS);
  localparam logic [CH_W-1:0] CH_LAST    = CH_W'(CHANNELS - 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DITHER       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CENTRE = 3'd4;

  // Reset values
  localparam logic [GAIN_W-1:0]   RST_STEP_GAIN = 12'd200;
  localparam logic [DITHER_W-1:0] RST_DITHER    = 10'd40;
  localparam logic [LEVEL_W-1:0]  RST_MAX       = 12'd4095;
  localparam logic [LEVEL_W-1:0]  RST_MIN       = 12'd0;
  localparam logic [LEVEL_W-1:0]  RST_CENTRE    = 12'd2047;
  localparam logic [LEVEL_W-1:0]  RST_LEVEL     = 12'd2047;
  localparam logic [LEVEL_W-1:0]  LEVEL_TOP     = 12'd4095;

  typedef struct packed {
    logic [1:0]         channel;
    logic [LEVEL_W-1:0] value;
    logic               last;
  } res_t;

  typedef struct packed {
    logic                start;
    logic [DVD_W-1:0]    dividend;
    logic [DITHER_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hw/rtl/cdd_div.sv]
// ----------------------------------------------------------------------------
// cdd_div - serial restoring divider
// Unsigned dividend over a nonzero divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cdd_div (
  input  logic              clk,
  input  logic              rst,
  input  cdd_pkg::div_req_t req,
  output cdd_pkg::div_rsp_t rsp
);

  logic [cdd_pkg::DVD_W-1:0]    acc;
  logic [cdd_pkg::DITHER_W-1:0] rem;
  logic [cdd_pkg::DITHER_W-1:0] dvs;
  logic [cdd_pkg::CNT_W-1:0]    cnt;
  logic                         busy;
  logic                         done;

  logic [cdd_pkg::DITHER_W:0]   trial;
  logic                         ge;
  logic [cdd_pkg::DITHER_W:0]   diff;

  assign trial = {rem, acc[cdd_pkg::DVD_W-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        acc  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= cdd_pkg::CNT_W'(cdd_pkg::DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        // shift in one quotient bit, keep the partial remainder
        rem <= ge ? diff[cdd_pkg::DITHER_W-1:0] : trial[cdd_pkg::DITHER_W-1:0];
        acc <= {acc[cdd_pkg::DVD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == cdd_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = acc;

endmodule

[hw/rtl/cdd_outq.sv]
// ----------------------------------------------------------------------------
// cdd_outq - two-entry result queue
// Holds DAC writes until the receiver takes them.
// ----------------------------------------------------------------------------
module cdd_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cdd_pkg::res_t push_data,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output cdd_pkg::res_t head
);

  cdd_pkg::res_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          pop;

  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= push_data;
        wr_ptr      <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/coordinate_dither_descent.sv]
// ----------------------------------------------------------------------------
// coordinate_dither_descent - dither descent controller for DAC channels
// Turns photodetector samples into DAC writes, one channel at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / adc_sample): one sample per phase
//   of a round. A round is a baseline sample, then a low and a high probe
//   sample per channel. Output channel (out_valid / out_ready with
//   dac_channel, dac_value, last): the DAC writes each sample causes, one or
//   two, last set on the final one.
//   Baseline and low-probe samples go straight to their probe write. A high
//   probe runs a 13x12 multiply, then a 24-step serial division for the
//   gradient and, for an in-range level, a second 24-step division for the
//   spring term. The block takes the next sample once the sequencer is back
//   in idle. Results go to a two-entry queue, so a stalled receiver holds
//   the sequencer only when the queue is full; no write is dropped.
//   Reset (rst, synchronous) restores the register defaults, sets every
//   channel level to 2047, clears the baseline and waits for a baseline.
//   Configuration (cfg_we / cfg_index / cfg_data) is to be written while
//   idle by the user; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module coordinate_dither_descent (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cdd_pkg::SAMPLE_W-1:0]     adc_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       dac_channel,
  output logic [cdd_pkg::LEVEL_W-1:0]      dac_value,
  output logic                             last,
  input  logic                             cfg_we,
  input  logic [cdd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cdd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_MUL,
    S_DIV1,
    S_DIV1_WAIT,
    S_EVAL,
    S_DIV2_WAIT,
    S_WRITE
  } state_t;

  // Clamp a signed level into converter range
  function automatic logic [cdd_pkg::LEVEL_W-1:0] clamp12(input logic signed [25:0] v);
    logic [cdd_pkg::LEVEL_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({14'd0, cdd_pkg::LEVEL_TOP})) begin
      r = cdd_pkg::LEVEL_TOP;
    end else begin
      r = v[cdd_pkg::LEVEL_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [cdd_pkg::GAIN_W-1:0]   step_gain;
  logic [cdd_pkg::DITHER_W-1:0] dither_amount;
  logic [cdd_pkg::LEVEL_W-1:0]  level_max;
  logic [cdd_pkg::LEVEL_W-1:0]  level_min;
  logic [cdd_pkg::LEVEL_W-1:0]  level_centre;

  // Sequencer state
  state_t                       state;
  logic [cdd_pkg::PH_W-1:0]     phase;
  logic [cdd_pkg::SAMPLE_W-1:0] baseline;
  logic [cdd_pkg::SAMPLE_W-1:0] sample;
  logic [cdd_pkg::CH_W-1:0]     idx;
  logic                         probe_up;
  logic signed [25:0]           prod;
  logic signed [25:0]           nval;
  logic                         off_neg;
  logic [cdd_pkg::LEVEL_W-1:0]  nlvl;
  logic [cdd_pkg::LEVEL_W-1:0]  levels [cdd_pkg::CHANNELS];

  // Decode of the current phase
  logic                         phase_base;
  logic [cdd_pkg::PH_W-1:0]     phase_half;
  logic [cdd_pkg::PH_W-1:0]     half_m1;
  logic [cdd_pkg::CH_W-1:0]     ch_low;
  logic [cdd_pkg::CH_W-1:0]     ch_high;
  logic                         accept;

  // Datapath
  logic [cdd_pkg::LEVEL_W-1:0]  lvl_rd;
  logic signed [13:0]           probe_sum;
  logic [cdd_pkg::LEVEL_W-1:0]  probe_val;
  logic signed [12:0]           sdiff;
  logic [25:0]                  prod_mag;
  logic signed [25:0]           n_calc;
  logic                         over_max;
  logic                         under_min;
  logic signed [12:0]           off;
  logic [12:0]                  off_mag;
  logic signed [13:0]           spring;
  logic signed [13:0]           refl_hi;
  logic signed [13:0]           refl_lo;
  logic [cdd_pkg::DITHER_W-1:0] div_den;
  logic                         is_last;
  logic [cdd_pkg::CH_W+1:0]     idx_ext;

  cdd_pkg::div_req_t            div_req;
  cdd_pkg::div_rsp_t            div_rsp;
  cdd_pkg::res_t                push_data;
  logic                         push;
  logic                         q_space;
  cdd_pkg::res_t                q_head;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;

  assign phase_base = (phase == cdd_pkg::PHASE_BASE) || (phase > cdd_pkg::PHASE_MAX);
  assign phase_half = phase >> 1;
  assign half_m1    = phase_half - cdd_pkg::PH_W'(1);
  assign ch_low     = phase_half[cdd_pkg::CH_W-1:0];
  assign ch_high    = half_m1[cdd_pkg::CH_W-1:0];

  assign lvl_rd     = levels[idx];
  assign is_last    = (idx == cdd_pkg::CH_LAST);
  assign idx_ext    = {2'b00, idx};

  // Probe level: stored level plus or minus one dither
  assign probe_sum  = probe_up
                      ? $signed({2'b00, lvl_rd}) + $signed({4'd0, dither_amount})
                      : $signed({2'b00, lvl_rd}) - $signed({4'd0, dither_amount});
  assign probe_val  = clamp12(26'(probe_sum));

  // Gradient inputs
  assign sdiff      = $signed({1'b0, sample}) - $signed({1'b0, baseline});
  assign prod_mag   = prod[25] ? 26'(-prod) : 26'(prod);
  assign n_calc     = prod[25]
                      ? $signed({14'd0, lvl_rd}) + $signed({2'b00, div_rsp.quotient})
                      : $signed({14'd0, lvl_rd}) - $signed({2'b00, div_rsp.quotient});

  // Saturation tests, in order: above max first, then below min
  assign over_max   = (nval > $signed({14'd0, level_max}));
  assign under_min  = (nval < $signed({14'd0, level_min}));
  assign refl_hi    = $signed({2'b00, level_max}) - $signed({4'd0, dither_amount});
  assign refl_lo    = $signed({2'b00, level_min}) + $signed({4'd0, dither_amount});
  assign off        = $signed({1'b0, nval[11:0]}) - $signed({1'b0, level_centre});
  assign off_mag    = off[12] ? 13'(-off) : 13'(off);
  assign spring     = off_neg
                      ? $signed({2'b00, nval[11:0]}) + $signed({2'b00, div_rsp.quotient[11:0]})
                      : $signed({2'b00, nval[11:0]}) - $signed({2'b00, div_rsp.quotient[11:0]});

  // Zero dither divides as one
  assign div_den    = (dither_amount == '0) ? cdd_pkg::DITHER_W'(1) : dither_amount;

  always_comb begin
    div_req.divisor = div_den;
    if (state == S_DIV1) begin
      div_req.start    = 1'b1;
      div_req.dividend = prod_mag[cdd_pkg::DVD_W-1:0];
    end else begin
      div_req.start    = (state == S_EVAL) && !over_max && !under_min;
      div_req.dividend = cdd_pkg::DVD_W'(off_mag);
    end
  end

  // Result selection: probe write or updated level
  always_comb begin
    push_data.channel = idx_ext[1:0];
    if (state == S_WRITE) begin
      push_data.value = nlvl;
      push_data.last  = is_last;
    end else begin
      push_data.value = probe_val;
      push_data.last  = 1'b1;
    end
    push = ((state == S_WRITE) || (state == S_PROBE)) && q_space;
  end

  cdd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  cdd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (q_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (q_head)
  );

  assign dac_channel = q_head.channel;
  assign dac_value   = q_head.value;
  assign last        = q_head.last;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_gain     <= cdd_pkg::RST_STEP_GAIN;
      dither_amount <= cdd_pkg::RST_DITHER;
      level_max     <= cdd_pkg::RST_MAX;
      level_min     <= cdd_pkg::RST_MIN;
      level_centre  <= cdd_pkg::RST_CENTRE;
    end else if (cfg_we) begin
      case (cfg_index)
        cdd_pkg::REG_STEP_GAIN:    step_gain     <= cfg_data[cdd_pkg::GAIN_W-1:0];
        cdd_pkg::REG_DITHER:       dither_amount <= cfg_data[cdd_pkg::DITHER_W-1:0];
        cdd_pkg::REG_LEVEL_MAX:    level_max     <= cfg_data[cdd_pkg::LEVEL_W-1:0];
        cdd_pkg::REG_LEVEL_MIN:    level_min     <= cfg_data[cdd_pkg::LEVEL_W-1:0];
        cdd_pkg::REG_LEVEL_CENTRE: level_centre  <= cfg_data[cdd_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= cdd_pkg::PHASE_BASE;
      baseline <= '0;
      idx      <= '0;
      probe_up <= 1'b0;
      for (int i = 0; i < cdd_pkg::CHANNELS; i++) begin
        levels[i] <= cdd_pkg::RST_LEVEL;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (phase_base) begin
              // baseline: store it, probe channel 0 low
              baseline <= adc_sample;
              phase    <= cdd_pkg::PH_W'(1);
              idx      <= '0;
              probe_up <= 1'b0;
              state    <= S_PROBE;
            end else if (phase[0]) begin
              // low probe: drop the sample, probe the channel high
              idx      <= ch_low;
              probe_up <= 1'b1;
              phase    <= phase + 1'b1;
              state    <= S_PROBE;
            end else begin
              // high probe: run the level update
              idx    <= ch_high;
              sample <= adc_sample;
              phase  <= (ch_high == cdd_pkg::CH_LAST) ? cdd_pkg::PHASE_BASE
                                                      : phase + 1'b1;
              state  <= S_MUL;
            end
          end
        end
        S_PROBE: begin
          if (q_space) begin
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          prod  <= sdiff * $signed({1'b0, step_gain});
          state <= S_DIV1;
        end
        S_DIV1: begin
          state <= S_DIV1_WAIT;
        end
        S_DIV1_WAIT: begin
          if (div_rsp.done) begin
            nval  <= n_calc;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (over_max) begin
            nlvl  <= clamp12(26'(refl_hi));
            state <= S_WRITE;
          end else if (under_min) begin
            nlvl  <= clamp12(26'(refl_lo));
            state <= S_WRITE;
          end else begin
            off_neg <= off[12];
            state   <= S_DIV2_WAIT;
          end
        end
        S_DIV2_WAIT: begin
          if (div_rsp.done) begin
            nlvl  <= clamp12(26'(spring));
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (q_space) begin
            levels[idx] <= nlvl;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              // advance to the next channel's low probe
              idx      <= idx + 1'b1;
              probe_up <= 1'b0;
              state    <= S_PROBE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("sequencer ready right after a transaction");

  a_div_start_idle : assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_phase_range : assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (phase <= cdd_pkg::PHASE_MAX))
    else $error("round phase left the round");

  a_done_waited : assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV1_WAIT) || (state == S_DIV2_WAIT))
    else $error("division finished with no one waiting");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for coordinate_dither_descent
// Feeds photodetector samples through the valid/ready input, mirrors the
// dither descent in a local predictor and checks every DAC write that
// comes out, field by field and in order. Register settings change only
// between phases, once every predicted write has arrived.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int RANDOM_ITEMS   = 850;
  localparam int DRAIN_CYCLES   = 64;    // one high-probe latency and margin
  localparam int PRESSURE_PHASE = 3;

  // Indexes past the register file; writes there must change nothing
  localparam logic [cdd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [cdd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Two full rounds that reflect off the low and the high bound, then part
  // of a round with small differences so the spring term applies.
  localparam logic [cdd_pkg::SAMPLE_W-1:0] DIRECTED [25] = '{
    12'd0,    12'd100,  12'd4095, 12'd0,    12'd4095, 12'd4095, 12'd4095, 12'd0,    12'd4095,
    12'd4095, 12'd4095, 12'd0,    12'd0,    12'd0,    12'd4095, 12'd0,    12'd1,    12'd0,
    12'd2048, 12'd4095, 12'd2050, 12'd0,    12'd2040, 12'd1234, 12'd2047
  };

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [cdd_pkg::SAMPLE_W-1:0]    adc_sample = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      dac_channel;
  logic [cdd_pkg::LEVEL_W-1:0]     dac_value;
  logic                            last;
  logic                            cfg_we = 1'b0;
  logic [cdd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [cdd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  coordinate_dither_descent dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .adc_sample  (adc_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .dac_channel (dac_channel),
    .dac_value   (dac_value),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the descent state
  // --------------------------------------------------------------------------
  logic [cdd_pkg::GAIN_W-1:0]   gain_m;
  logic [cdd_pkg::DITHER_W-1:0] dither_m;
  logic [cdd_pkg::LEVEL_W-1:0]  max_m;
  logic [cdd_pkg::LEVEL_W-1:0]  min_m;
  logic [cdd_pkg::LEVEL_W-1:0]  centre_m;
  logic [cdd_pkg::LEVEL_W-1:0]  model_level [cdd_pkg::CHANNELS];
  logic [cdd_pkg::SAMPLE_W-1:0] model_base;
  int                           model_phase;

  cdd_pkg::res_t                dac_write_q [$];    // predicted DAC writes, oldest first
  logic [cdd_pkg::SAMPLE_W-1:0] pending_samples [$];

  // State of the stimulus, driver, receiver and monitor
  bit  in_taken;
  bit  sender_gaps;
  bit  receiver_stalls;
  bit  hold_request;
  int  send_gap;
  int  stall_left;
  int  hold_left;
  int  errors;
  int  quiet_cycles;
  int  gen_slot;
  logic [cdd_pkg::SAMPLE_W-1:0] gen_base;

  function automatic logic [cdd_pkg::LEVEL_W-1:0] clamp_level(int v);
    if (v < 0) return '0;
    if (v > int'(cdd_pkg::LEVEL_TOP)) return cdd_pkg::LEVEL_TOP;
    return cdd_pkg::LEVEL_W'(v);
  endfunction

  function automatic void push_write(int ch, logic [cdd_pkg::LEVEL_W-1:0] val, bit fin);
    cdd_pkg::res_t w;
    w.channel = 2'(ch);
    w.value   = val;
    w.last    = fin;
    dac_write_q.push_back(w);
  endfunction

  function automatic void reset_descent();
    gain_m      = cdd_pkg::RST_STEP_GAIN;
    dither_m    = cdd_pkg::RST_DITHER;
    max_m       = cdd_pkg::RST_MAX;
    min_m       = cdd_pkg::RST_MIN;
    centre_m    = cdd_pkg::RST_CENTRE;
    model_base  = '0;
    model_phase = 0;
    foreach (model_level[i]) model_level[i] = cdd_pkg::RST_LEVEL;
  endfunction

  // Work out the DAC writes one accepted sample causes
  function automatic void predict_dac_writes(logic [cdd_pkg::SAMPLE_W-1:0] s);
    int d, div, diff, grad, n, ch;
    d   = int'(dither_m);
    div = (dither_m == '0) ? 1 : int'(dither_m);
    if (model_phase == 0 || model_phase > 2 * cdd_pkg::CHANNELS) begin
      model_base  = s;
      model_phase = 1;
      push_write(0, clamp_level(int'(model_level[0]) - d), 1'b1);
    end else if (model_phase % 2 == 1) begin
      // low probe: sample dropped, probe above the level
      ch = (model_phase - 1) / 2;
      model_phase++;
      push_write(ch, clamp_level(int'(model_level[ch]) + d), 1'b1);
    end else begin
      ch   = model_phase / 2 - 1;
      diff = int'(s) - int'(model_base);
      grad = diff * int'(gain_m) / div;
      n    = int'(model_level[ch]) - grad;
      if (n > int'(max_m))
        n = int'(max_m) - d;
      else if (n < int'(min_m))
        n = int'(min_m) + d;
      else
        n = n - (n - int'(centre_m)) / div;
      model_level[ch] = clamp_level(n);
      if (ch + 1 < cdd_pkg::CHANNELS) begin
        push_write(ch, model_level[ch], 1'b0);
        push_write(ch + 1, clamp_level(int'(model_level[ch + 1]) - d), 1'b1);
        model_phase++;
      end else begin
        push_write(ch, model_level[ch], 1'b1);
        model_phase = 0;
      end
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: drop the sample once accepted, then offer the next after any gap
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    logic                         offer;
    logic [cdd_pkg::SAMPLE_W-1:0] word;
    offer = in_valid;
    word  = adc_sample;
    if (in_taken) begin
      offer    = 1'b0;
      in_taken = 1'b0;
    end
    if (!offer) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_samples.size() != 0) begin
        word     = pending_samples.pop_front();
        offer    = 1'b1;
        send_gap = sender_gaps ? draw_gap() : 0;
      end
    end
    in_valid   <= offer;
    adc_sample <= word;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
      stall_left = draw_gap();
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check writes first so a sample accepted on the same edge can
  // never mask an unexpected write, then predict from the new sample.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cdd_pkg::res_t want;
    bit            moved;
    moved = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (dac_write_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected DAC write ch=%0d value=%0d last=%0b",
                     $realtime, dac_channel, dac_value, last);
        end else begin
          want = dac_write_q.pop_front();
          if (dac_channel !== want.channel || dac_value !== want.value ||
              last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $write("%0t: DAC write mismatch: expected ch=%0d value=%0d last=%0b",
                     $realtime, want.channel, want.value, want.last);
              $display(", got ch=%0d value=%0d last=%0b", dac_channel, dac_value, last);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        predict_dac_writes(adc_sample);
        in_taken = 1'b1;
      end
    end
    // Watchdog: a hung block stops both transactions
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Queue one sample and track where it lands in the round
  task automatic add_sample(logic [cdd_pkg::SAMPLE_W-1:0] v);
    if (gen_slot == 0) gen_base = v;
    pending_samples.push_back(v);
    gen_slot = (gen_slot + 1) % (2 * cdd_pkg::CHANNELS + 1);
  endtask

  // Random content shaped by the slot: high probes mostly near the baseline
  // so levels stay in range and the spring term gets exercised
  function automatic logic [cdd_pkg::SAMPLE_W-1:0] draw_sample();
    int r, v;
    r = $urandom_range(0, 99);
    if (gen_slot != 0 && gen_slot % 2 == 0 && r < 60) begin
      v = int'(gen_base) + $urandom_range(0, 40) - 20;
      return cdd_pkg::LEVEL_W'(v < 0 ? 0 : (v > 4095 ? 4095 : v));
    end
    if (r >= 88) return (r % 2 == 0) ? '0 : '1;
    return cdd_pkg::SAMPLE_W'($urandom_range(0, 4095));
  endfunction

  // Write one register, keep the predictor copy in step, release the strobe
  task automatic cfg_write(logic [cdd_pkg::CFG_IDX_W-1:0] idx,
                           logic [cdd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      cdd_pkg::REG_STEP_GAIN:    gain_m   = data;
      cdd_pkg::REG_DITHER:       dither_m = data[cdd_pkg::DITHER_W-1:0];
      cdd_pkg::REG_LEVEL_MAX:    max_m    = data;
      cdd_pkg::REG_LEVEL_MIN:    min_m    = data;
      cdd_pkg::REG_LEVEL_CENTRE: centre_m = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(int gain, int dither, int hi, int lo, int mid);
    cfg_write(cdd_pkg::REG_STEP_GAIN,    cdd_pkg::CFG_DATA_W'(gain));
    cfg_write(cdd_pkg::REG_DITHER,       cdd_pkg::CFG_DATA_W'(dither));
    cfg_write(cdd_pkg::REG_LEVEL_MAX,    cdd_pkg::CFG_DATA_W'(hi));
    cfg_write(cdd_pkg::REG_LEVEL_MIN,    cdd_pkg::CFG_DATA_W'(lo));
    cfg_write(cdd_pkg::REG_LEVEL_CENTRE, cdd_pkg::CFG_DATA_W'(mid));
  endtask

  // Hold until every sample is taken and every predicted write has come.
  // Sample just after the falling edge so the driver has settled.
  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (pending_samples.size() != 0 || in_valid || dac_write_q.size() != 0);
  endtask

  task automatic apply_setting(int k);
    int a, b, dither;
    case (k)
      0: write_all(1, 1, 4095, 0, 0);               // smallest nonzero gain and dither
      1: write_all(4095, 1023, 4095, 4095, 4095);   // min + dither past the top
      2: write_all(4095, 1023, 0, 0, 0);            // max - dither below zero
      3: write_all(300, 0, 3000, 1000, 2000);       // zero dither
      4: write_all(100, 20, 1000, 3000, 2047);      // crossed bounds
      5: begin
        // upper data bits past the dither field, then writes to spare indexes
        write_all(200, 12'hC00 | 40, 3500, 500, 2000);
        cfg_write(REG_SPARE_LO, 12'hFFF);
        cfg_write(REG_SPARE_HI, 12'h555);
      end
      default: begin
        a = $urandom_range(0, 4095);
        b = $urandom_range(0, 4095);
        if ($urandom_range(0, 9) == 0) dither = 0;
        else if ($urandom_range(0, 3) == 0) dither = $urandom_range(1, 1023);
        else dither = $urandom_range(1, 80);
        if ($urandom_range(0, 9) != 0 && a < b) begin
          // normal ordering: max above min
          write_all($urandom_range(1, 4095), dither, b, a,
                    ($urandom_range(0, 1) != 0) ? (a + b) / 2 : $urandom_range(0, 4095));
        end else begin
          write_all($urandom_range(1, 4095), dither, a, b, $urandom_range(0, 4095));
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int random_items;
    int phase_no;
    int n;
    random_items = 0;
    reset_descent();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed samples under the reset register values, no idling
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    foreach (DIRECTED[i]) add_sample(DIRECTED[i]);
    wait_idle();

    // Each phase: new settings while idle, then random samples
    for (phase_no = 0; random_items < RANDOM_ITEMS; phase_no++) begin
      apply_setting(phase_no);
      if (phase_no == PRESSURE_PHASE) begin
        // keep offering with no gaps while the receiver is held off
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        hold_request    = 1'b1;
      end else begin
        sender_gaps     = ($urandom_range(0, 2) != 0);
        receiver_stalls = ($urandom_range(0, 2) != 0);
      end
      n = $urandom_range(50, 80);
      repeat (n) add_sample(draw_sample());
      random_items += n;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && dac_write_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/cdd_pkg.sv
hw/rtl/cdd_div.sv
hw/rtl/cdd_outq.sv
hw/rtl/coordinate_dither_descent.sv
verif/tb.sv
